>>> sv/iir_filter_transposed_df2_core_assert.svh
// assertion macros shared by the iir filter checker
`ifndef IIR_FILTER_TRANSPOSED_DF2_CORE_ASSERT_SVH
`define IIR_FILTER_TRANSPOSED_DF2_CORE_ASSERT_SVH

// checked on every rising edge of clk, quiet while rst_n is low
`define IIRTDF2_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge of clk, reset included
`define IIRTDF2_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/iirtdf2_pkg.sv
// shared types and constants of the transposed direct form ii iir filter
`default_nettype none

package iirtdf2_pkg;

  localparam int COEF_BITS  = 18;
  localparam int DELAY_BITS = 40;
  localparam int DELAY_FRAC = 28;
  localparam int INDEX_BITS = 4;
  localparam int CMD_BITS   = 3;
  localparam int TAPS_BITS  = 4;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SAMPLE     = 3'd0,
    CMD_WR_NUM     = 3'd1,
    CMD_WR_DEN     = 3'd2,
    CMD_LOAD_DELAY = 3'd3,
    CMD_READ_DELAY = 3'd4
  } cmd_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_Y_MUL  = 7'b0000010,
    ST_Y_SAT  = 7'b0000100,
    ST_TAP_B  = 7'b0001000,
    ST_TAP_A  = 7'b0010000,
    ST_TAP_WB = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic load_x;
    logic mul_en;
    logic mul_sel_y;
    logic acc_load;
    logic acc_from_delay;
    logic acc_add;
    logic y_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

>>> sv/iirtdf2_ram.sv
// single-port-write, single-port-read ram with registered read and per-entry valid bits
`default_nettype none

module iirtdf2_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 9,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] q_r;
  logic [DEPTH-1:0] vld_r;
  logic             q_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      q_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = q_vld_r ? q_r : '0;

endmodule

`default_nettype wire

>>> sv/iirtdf2_mac.sv
// shared multiplier, rounding, accumulator and saturation of the filter
`default_nettype none

module iirtdf2_mac #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                        clk,
  input  iirtdf2_pkg::mac_ctrl_t                      ctrl,
  input  logic signed [SAMPLE_BITS-1:0]               sample,
  input  logic signed [iirtdf2_pkg::COEF_BITS-1:0]    coef,
  input  logic signed [iirtdf2_pkg::DELAY_BITS-1:0]   delay,
  output logic signed [SAMPLE_BITS-1:0]               y,
  output logic                                        clip,
  output logic signed [iirtdf2_pkg::DELAY_BITS-1:0]   wb_data
);

  localparam int CB = iirtdf2_pkg::COEF_BITS;
  localparam int DB = iirtdf2_pkg::DELAY_BITS;
  localparam int DF = iirtdf2_pkg::DELAY_FRAC;
  localparam int SF = SAMPLE_BITS - 1;

  localparam int PW     = CB + SAMPLE_BITS;
  localparam int PF     = COEF_FRAC_BITS + SAMPLE_BITS - 1;
  localparam int P_SHR  = (PF > DF) ? PF - DF : 0;
  localparam int P_SHL  = (DF > PF) ? DF - PF : 0;
  localparam int P_HALF = (1 << P_SHR) >> 1;
  localparam int PE     = PW + P_SHL + 1;

  // delay word plus two scaled products stays well inside this
  localparam int ACC_W  = DB + 3;

  localparam int Y_SHR  = (DF > SF) ? DF - SF : 0;
  localparam int Y_SHL  = (SF > DF) ? SF - DF : 0;
  localparam int Y_HALF = (1 << Y_SHR) >> 1;
  localparam int YE     = ACC_W + Y_SHL + 1;

  localparam logic signed [YE-1:0]    Y_MAX = YE'({1'b0, {SF{1'b1}}});
  localparam logic signed [YE-1:0]    Y_MIN = ~Y_MAX;
  localparam logic signed [ACC_W-1:0] D_MAX = ACC_W'({1'b0, {(DB-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] D_MIN = ~D_MAX;

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic                          clip_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [ACC_W-1:0]       acc_r;

  logic signed [SAMPLE_BITS-1:0] mul_op;
  logic signed [PE-1:0]          p_ext;
  logic signed [PE-1:0]          p_scaled;
  logic signed [ACC_W-1:0]       p_term;
  logic signed [ACC_W-1:0]       acc_sum;
  logic signed [ACC_W-1:0]       acc_diff;
  logic signed [YE-1:0]          y_ext;
  logic signed [YE-1:0]          y_scaled;
  logic                          y_hi;
  logic                          y_lo;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  always_comb begin
    mul_op   = ctrl.mul_sel_y ? y_r : x_r;
    // product to delay-word fraction, round half up
    p_ext    = PE'(prod_r);
    p_scaled = ((p_ext + PE'(P_HALF)) >>> P_SHR) <<< P_SHL;
    p_term   = ACC_W'(p_scaled);
    acc_sum  = acc_r + p_term;
    acc_diff = acc_r - p_term;
    // wide output to sample fraction, round half up, then clamp
    y_ext    = YE'(acc_sum);
    y_scaled = ((y_ext + YE'(Y_HALF)) >>> Y_SHR) <<< Y_SHL;
    y_hi     = y_scaled > Y_MAX;
    y_lo     = y_scaled < Y_MIN;
    if (y_hi) begin
      y_sat = SAMPLE_BITS'(Y_MAX);
    end else if (y_lo) begin
      y_sat = SAMPLE_BITS'(Y_MIN);
    end else begin
      y_sat = SAMPLE_BITS'(y_scaled);
    end
    if (acc_diff > D_MAX) begin
      wb_data = DB'(D_MAX);
    end else if (acc_diff < D_MIN) begin
      wb_data = DB'(D_MIN);
    end else begin
      wb_data = DB'(acc_diff);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_x) begin
      x_r <= sample;
    end
    if (ctrl.mul_en) begin
      prod_r <= PW'(coef) * PW'(mul_op);
    end
    if (ctrl.acc_load) begin
      acc_r <= ctrl.acc_from_delay ? ACC_W'(delay) : '0;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_sum;
    end
    if (ctrl.y_en) begin
      y_r    <= y_sat;
      clip_r <= y_hi | y_lo;
    end
  end

  assign y    = y_r;
  assign clip = clip_r;

endmodule

`default_nettype wire

>>> sv/iir_filter_transposed_df2_core.sv
// iir filter core in transposed direct form ii: sequencer, memories and datapath
//
// Usage: items arrive on the in_ channel (valid/stall). in_command picks the work:
// filter in_sample, write numerator or denominator coefficient in_index, load
// delay word in_index from in_state_word, or read delay word in_index back.
// Every item gives exactly one result item on the out_ channel (valid/stall);
// fields a command does not produce are zero. cfg_taps_in_use sets the filter
// order through a valid/ready port that is always ready; write it only while idle.
// A sample item passes ST_Y_MUL and ST_Y_SAT, then the taps of the order in use;
// other commands go straight to ST_DONE. No new item is taken until the result is
// loaded into the output register. Each tap needs two reads of the single
// coefficient memory port and two passes through the one shared multiplier,
// plus a write-back, so each tap runs through ST_TAP_B, ST_TAP_A and ST_TAP_WB.
// Reset (rst_n low, synchronous) clears the order, the valid bits of all
// coefficients and delay words (they read as zero) and the output valid flag.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and its result waits until the register is free.
`default_nettype none

module iir_filter_transposed_df2_core #(
  parameter int MAX_ORDER      = 8,
  parameter int COEF_FRAC_BITS = 14,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [iirtdf2_pkg::TAPS_BITS-1:0]           cfg_taps_in_use,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic [iirtdf2_pkg::CMD_BITS-1:0]            in_command,
  input  logic [iirtdf2_pkg::INDEX_BITS-1:0]          in_index,
  input  logic signed [SAMPLE_BITS-1:0]               in_sample,
  input  logic signed [iirtdf2_pkg::COEF_BITS-1:0]    in_coefficient,
  input  logic signed [iirtdf2_pkg::DELAY_BITS-1:0]   in_state_word,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic signed [SAMPLE_BITS-1:0]               out_filtered,
  output logic                                        out_clipped,
  output logic signed [iirtdf2_pkg::DELAY_BITS-1:0]   out_state_read
);

  localparam int CB     = iirtdf2_pkg::COEF_BITS;
  localparam int DB     = iirtdf2_pkg::DELAY_BITS;
  localparam int CDEPTH = 2 * MAX_ORDER + 2;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int DAW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int NW     = $clog2(MAX_ORDER + 1);

  // denominator coefficients sit above the numerator ones
  localparam logic [CAW-1:0] A_BASE = CAW'(MAX_ORDER + 1);
  localparam logic [31:0]    MAX_U  = 32'(MAX_ORDER);

  iirtdf2_pkg::state_t    state_r, state_nxt;
  iirtdf2_pkg::cmd_t      cmd;
  iirtdf2_pkg::mac_ctrl_t ctrl;

  logic [iirtdf2_pkg::TAPS_BITS-1:0] taps_r;
  logic [NW-1:0]                     n_eff;
  logic [NW-1:0]                     j_r, j_nxt;
  logic [NW:0]                       jp1, jp2, n_ext;
  logic                              is_sample_r, is_sample_nxt;
  logic                              rd_ok_r, rd_ok_nxt;
  logic [DAW-1:0]                    rd_addr_r, rd_addr_nxt;

  logic                              idx_le_max, idx_lt_max;

  logic                              c_we;
  logic [CAW-1:0]                    c_waddr, c_raddr;
  logic [CB-1:0]                     c_wdata, c_rdata;
  logic                              d_we;
  logic [DAW-1:0]                    d_waddr, d_raddr;
  logic [DB-1:0]                     d_wdata, d_rdata;

  logic signed [SAMPLE_BITS-1:0]     y;
  logic                              clip;
  logic signed [DB-1:0]              wb_data;

  logic                              out_valid_r, out_valid_nxt;
  logic                              out_load;
  logic signed [SAMPLE_BITS-1:0]     out_filtered_r;
  logic                              out_clipped_r;
  logic signed [DB-1:0]              out_state_read_r;

  assign cmd        = iirtdf2_pkg::cmd_t'(in_command);
  assign idx_le_max = 32'(in_index) <= MAX_U;
  assign idx_lt_max = 32'(in_index) < MAX_U;
  assign n_eff      = (32'(taps_r) > MAX_U) ? NW'(MAX_ORDER) : NW'(taps_r);
  assign jp1        = (NW+1)'(j_r) + (NW+1)'(1);
  assign jp2        = (NW+1)'(j_r) + (NW+1)'(2);
  assign n_ext      = (NW+1)'(n_eff);

  assign in_stall   = (state_r != iirtdf2_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_load   = (state_r == iirtdf2_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    is_sample_nxt = is_sample_r;
    rd_ok_nxt     = rd_ok_r;
    rd_addr_nxt   = rd_addr_r;
    ctrl          = '0;
    c_we          = 1'b0;
    c_waddr       = '0;
    c_wdata       = in_coefficient;
    c_raddr       = '0;
    d_we          = 1'b0;
    d_waddr       = '0;
    d_wdata       = in_state_word;
    d_raddr       = '0;

    case (state_r)
      iirtdf2_pkg::ST_IDLE: begin
        if (in_valid) begin
          is_sample_nxt = 1'b0;
          rd_ok_nxt     = 1'b0;
          rd_addr_nxt   = '0;
          state_nxt     = iirtdf2_pkg::ST_DONE;
          case (cmd)
            iirtdf2_pkg::CMD_SAMPLE: begin
              // read b0 and s0 for the output term
              ctrl.load_x   = 1'b1;
              is_sample_nxt = 1'b1;
              state_nxt     = iirtdf2_pkg::ST_Y_MUL;
            end
            iirtdf2_pkg::CMD_WR_NUM: begin
              c_we    = idx_le_max;
              c_waddr = CAW'(in_index);
            end
            iirtdf2_pkg::CMD_WR_DEN: begin
              // a0 is implied and never stored
              c_we    = idx_le_max && (in_index != '0);
              c_waddr = CAW'(in_index) + A_BASE;
            end
            iirtdf2_pkg::CMD_LOAD_DELAY: begin
              d_we    = idx_lt_max;
              d_waddr = DAW'(in_index);
            end
            iirtdf2_pkg::CMD_READ_DELAY: begin
              rd_ok_nxt   = idx_lt_max;
              rd_addr_nxt = idx_lt_max ? DAW'(in_index) : '0;
              d_raddr     = rd_addr_nxt;
            end
            default: begin
              state_nxt = iirtdf2_pkg::ST_DONE;
            end
          endcase
        end
      end
      iirtdf2_pkg::ST_Y_MUL: begin
        ctrl.mul_en         = 1'b1;
        ctrl.acc_load       = 1'b1;
        ctrl.acc_from_delay = (n_eff != '0);
        state_nxt           = iirtdf2_pkg::ST_Y_SAT;
      end
      iirtdf2_pkg::ST_Y_SAT: begin
        ctrl.y_en = 1'b1;
        j_nxt     = '0;
        c_raddr   = CAW'(1);
        d_raddr   = (n_ext > (NW+1)'(1)) ? DAW'(1) : '0;
        state_nxt = (n_eff == '0) ? iirtdf2_pkg::ST_DONE : iirtdf2_pkg::ST_TAP_B;
      end
      iirtdf2_pkg::ST_TAP_B: begin
        // b[j+1]*x on top of s[j+1], the last tap has no upper neighbor
        ctrl.mul_en         = 1'b1;
        ctrl.acc_load       = 1'b1;
        ctrl.acc_from_delay = (jp1 < n_ext);
        c_raddr             = A_BASE + CAW'(jp1);
        state_nxt           = iirtdf2_pkg::ST_TAP_A;
      end
      iirtdf2_pkg::ST_TAP_A: begin
        ctrl.mul_en    = 1'b1;
        ctrl.mul_sel_y = 1'b1;
        ctrl.acc_add   = 1'b1;
        state_nxt      = iirtdf2_pkg::ST_TAP_WB;
      end
      iirtdf2_pkg::ST_TAP_WB: begin
        d_we    = 1'b1;
        d_waddr = DAW'(j_r);
        d_wdata = wb_data;
        if (jp1 < n_ext) begin
          // fetch the next tap while s[j] goes back
          j_nxt     = NW'(jp1);
          c_raddr   = CAW'(jp2);
          d_raddr   = (jp2 < n_ext) ? DAW'(jp2) : '0;
          state_nxt = iirtdf2_pkg::ST_TAP_B;
        end else begin
          state_nxt = iirtdf2_pkg::ST_DONE;
        end
      end
      iirtdf2_pkg::ST_DONE: begin
        d_raddr = rd_addr_r;
        if (out_load) begin
          state_nxt = iirtdf2_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = iirtdf2_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iirtdf2_pkg::ST_IDLE;
      taps_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        taps_r <= cfg_taps_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r         <= j_nxt;
    is_sample_r <= is_sample_nxt;
    rd_ok_r     <= rd_ok_nxt;
    rd_addr_r   <= rd_addr_nxt;
    if (out_load) begin
      out_filtered_r   <= is_sample_r ? y : '0;
      out_clipped_r    <= is_sample_r & clip;
      out_state_read_r <= rd_ok_r ? DB'(d_rdata) : '0;
    end
  end

  iirtdf2_ram #(
    .WIDTH (CB),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  iirtdf2_ram #(
    .WIDTH (DB),
    .DEPTH (MAX_ORDER)
  ) u_delay_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  iirtdf2_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .ctrl    (ctrl),
    .sample  (in_sample),
    .coef    (c_rdata),
    .delay   (d_rdata),
    .y       (y),
    .clip    (clip),
    .wb_data (wb_data)
  );

  assign out_valid      = out_valid_r;
  assign out_filtered   = out_filtered_r;
  assign out_clipped    = out_clipped_r;
  assign out_state_read = out_state_read_r;

endmodule

`default_nettype wire

>>> sv/iirtdf2_checker.sv
// port-level checker of the iir filter core and its bind
`default_nettype none
`include "iir_filter_transposed_df2_core_assert.svh"

module iirtdf2_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                                        clk,
  input logic                                        rst_n,
  input logic                                        in_valid,
  input logic                                        in_stall,
  input logic                                        out_valid,
  input logic                                        out_stall,
  input logic signed [SAMPLE_BITS-1:0]               out_filtered,
  input logic                                        out_clipped,
  input logic signed [iirtdf2_pkg::DELAY_BITS-1:0]   out_state_read
);

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = ~S_MAX;

  `IIRTDF2_ASSERT_ANY(a_reset_clears, !rst_n |=> !out_valid && !in_stall, "reset left the block busy")

  `IIRTDF2_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_filtered) && $stable(out_clipped) && $stable(out_state_read), "stalled result changed")

  `IIRTDF2_ASSERT(a_one_item, in_valid && !in_stall |=> in_stall, "second item taken while busy")

  `IIRTDF2_ASSERT(a_clip_extreme, out_valid && out_clipped |-> out_filtered == S_MAX || out_filtered == S_MIN, "clipped output not at full scale")

  `IIRTDF2_ASSERT(a_one_kind, out_valid |-> out_state_read == '0 || (out_filtered == '0 && !out_clipped), "sample and readback fields both set")

endmodule

bind iir_filter_transposed_df2_core iirtdf2_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_iirtdf2_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_filtered   (out_filtered),
  .out_clipped    (out_clipped),
  .out_state_read (out_state_read)
);

`default_nettype wire

>>> dv/tb_iir_filter_transposed_df2_core.sv
// self-checking testbench for the transposed direct form ii iir filter core
module tb_iir_filter_transposed_df2_core;

  localparam int COEF_BITS      = iirtdf2_pkg::COEF_BITS;
  localparam int DELAY_BITS     = iirtdf2_pkg::DELAY_BITS;
  localparam int DELAY_FRAC     = iirtdf2_pkg::DELAY_FRAC;
  localparam int INDEX_BITS     = iirtdf2_pkg::INDEX_BITS;
  localparam int CMD_BITS       = iirtdf2_pkg::CMD_BITS;
  localparam int TAPS_BITS      = iirtdf2_pkg::TAPS_BITS;

  localparam int MAX_ORDER      = 8;
  localparam int COEF_FRAC_BITS = 14;
  localparam int SAMPLE_BITS    = 16;
  localparam int PROD_SHIFT     = COEF_FRAC_BITS + SAMPLE_BITS - 1 - DELAY_FRAC;
  localparam int Y_SHIFT        = DELAY_FRAC - (SAMPLE_BITS - 1);
  localparam int ITEM_TARGET    = 1300;
  localparam int SETTLE_CYCLES  = 3 * MAX_ORDER + 8;
  localparam int LONG_HOLD      = 300;
  localparam int CYCLE_LIMIT    = 500_000;

  localparam logic [CMD_BITS-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          clipped;
    logic signed [DELAY_BITS-1:0]  state_read;
  } filter_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TAPS_BITS-1:0] cfg_taps_in_use = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_BITS-1:0] in_command = '0;
  logic [INDEX_BITS-1:0] in_index = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic signed [COEF_BITS-1:0] in_coefficient = '0;
  logic signed [DELAY_BITS-1:0] in_state_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_filtered;
  logic out_clipped;
  logic signed [DELAY_BITS-1:0] out_state_read;

  // shadow of the filter state
  logic signed [COEF_BITS-1:0]  num_coef  [0:MAX_ORDER]   = '{default: '0};
  logic signed [COEF_BITS-1:0]  den_coef  [0:MAX_ORDER]   = '{default: '0};
  logic signed [DELAY_BITS-1:0] delay_mem [0:MAX_ORDER-1] = '{default: '0};
  logic [TAPS_BITS-1:0]         order_reg = '0;

  filter_out_t awaited_outputs[$];
  filter_out_t front_output;

  int errors = 0;
  int items_sent = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_request = 0;
  bit sender_gaps = 1'b1;
  stall_mode_t stall_mode = STALL_NONE;
  logic [15:0] orders_seen = '0;

  iir_filter_transposed_df2_core #(
    .MAX_ORDER(MAX_ORDER),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_taps_in_use(cfg_taps_in_use),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_index(in_index),
    .in_sample(in_sample),
    .in_coefficient(in_coefficient),
    .in_state_word(in_state_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_filtered(out_filtered),
    .out_clipped(out_clipped),
    .out_state_read(out_state_read)
  );

  always #1 clk = ~clk;

  // round half up on an arithmetic right shift
  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // coefficient times value, brought to delay word fraction bits
  function automatic longint scale_product(logic signed [COEF_BITS-1:0] c, longint v);
    longint p;
    p = longint'(c) * v;
    if (PROD_SHIFT > 0) return round_shift(p, PROD_SHIFT);
    return p <<< (-PROD_SHIFT);
  endfunction

  function automatic filter_out_t predict_filter_item(logic [CMD_BITS-1:0] cmd,
      logic [INDEX_BITS-1:0] idx, logic signed [SAMPLE_BITS-1:0] x,
      logic signed [COEF_BITS-1:0] c, logic signed [DELAY_BITS-1:0] sw);
    filter_out_t r;
    int n;
    int j;
    longint wide;
    longint y_wide;
    longint yv;
    longint next;
    r = '0;
    case (cmd)
      iirtdf2_pkg::CMD_SAMPLE: begin
        n = (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
        wide = scale_product(num_coef[0], x);
        if (n > 0) wide += longint'(delay_mem[0]);
        y_wide = round_shift(wide, Y_SHIFT);
        yv = clamp(y_wide, SAMPLE_BITS);
        // update runs upward so delay_mem[j+1] is still the old word
        for (j = 0; j < n; j++) begin
          next = (j + 1 < n) ? longint'(delay_mem[j + 1]) : longint'(0);
          next += scale_product(num_coef[j + 1], x) - scale_product(den_coef[j + 1], yv);
          delay_mem[j] = DELAY_BITS'(clamp(next, DELAY_BITS));
        end
        r.filtered = SAMPLE_BITS'(yv);
        r.clipped = (yv != y_wide);
      end
      iirtdf2_pkg::CMD_WR_NUM: begin
        if (idx <= MAX_ORDER) num_coef[idx] = c;
      end
      iirtdf2_pkg::CMD_WR_DEN: begin
        if (idx >= 1 && idx <= MAX_ORDER) den_coef[idx] = c;
      end
      iirtdf2_pkg::CMD_LOAD_DELAY: begin
        if (idx < MAX_ORDER) delay_mem[idx] = sw;
      end
      iirtdf2_pkg::CMD_READ_DELAY: begin
        if (idx < MAX_ORDER) r.state_read = delay_mem[idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [COEF_BITS-1:0] pick_coef();
    if ($urandom_range(0, 4) == 0) return COEF_BITS'($urandom);
    return COEF_BITS'($urandom_range(0, 8192)) - COEF_BITS'(4096);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    if ($urandom_range(0, 9) < 7) return SAMPLE_BITS'($urandom);
    return SAMPLE_BITS'($urandom_range(0, 1024)) - SAMPLE_BITS'(512);
  endfunction

  function automatic logic [DELAY_BITS-1:0] pick_state_word();
    if ($urandom_range(0, 1) == 0) return DELAY_BITS'({$urandom, $urandom});
    return DELAY_BITS'($urandom_range(0, 32'h8000_0000)) - DELAY_BITS'(32'h4000_0000);
  endfunction

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin : receiver
    int hold_len;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_len = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_mode == STALL_NONE) begin
        out_stall <= 1'b0;
      end else if (stall_mode == STALL_RANDOM) begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_outputs.size() == 0) begin
        $display("%0t: result item with nothing expected, filtered %0d state_read %0d",
                 $time, out_filtered, out_state_read);
        errors++;
      end else begin
        front_output = awaited_outputs.pop_front();
        results_checked++;
        if (out_filtered !== front_output.filtered) begin
          $display("%0t: filtered mismatch, expected %0d, actual %0d",
                   $time, front_output.filtered, out_filtered);
          errors++;
        end
        if (out_clipped !== front_output.clipped) begin
          $display("%0t: clipped mismatch, expected %0d, actual %0d",
                   $time, front_output.clipped, out_clipped);
          errors++;
        end
        if (out_state_read !== front_output.state_read) begin
          $display("%0t: state_read mismatch, expected %0d, actual %0d",
                   $time, front_output.state_read, out_state_read);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, awaited_outputs.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [CMD_BITS-1:0] cmd, logic [INDEX_BITS-1:0] idx,
      logic [SAMPLE_BITS-1:0] x, logic [COEF_BITS-1:0] c, logic [DELAY_BITS-1:0] sw);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_index <= idx;
    in_sample <= x;
    in_coefficient <= c;
    in_state_word <= sw;
    do @(posedge clk); while (in_stall);
    awaited_outputs.push_back(predict_filter_item(cmd, idx, x, c, sw));
    items_sent++;
    if (cmd == iirtdf2_pkg::CMD_SAMPLE) samples_sent++;
  endtask

  // fields a command does not use carry random junk
  task automatic filter_sample(logic [SAMPLE_BITS-1:0] x);
    send_item(iirtdf2_pkg::CMD_SAMPLE, INDEX_BITS'($urandom), x, COEF_BITS'($urandom),
              DELAY_BITS'({$urandom, $urandom}));
  endtask

  task automatic write_coef(logic [CMD_BITS-1:0] cmd, logic [INDEX_BITS-1:0] idx,
      logic [COEF_BITS-1:0] c);
    send_item(cmd, idx, SAMPLE_BITS'($urandom), c, DELAY_BITS'({$urandom, $urandom}));
  endtask

  task automatic load_delay(logic [INDEX_BITS-1:0] idx, logic [DELAY_BITS-1:0] sw);
    send_item(iirtdf2_pkg::CMD_LOAD_DELAY, idx, SAMPLE_BITS'($urandom),
              COEF_BITS'($urandom), sw);
  endtask

  task automatic read_delay(logic [INDEX_BITS-1:0] idx);
    send_item(iirtdf2_pkg::CMD_READ_DELAY, idx, SAMPLE_BITS'($urandom),
              COEF_BITS'($urandom), DELAY_BITS'({$urandom, $urandom}));
  endtask

  // wait until every result is back and the sequencer has wound down
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_order(logic [TAPS_BITS-1:0] taps);
    drain();
    cfg_taps_in_use <= taps;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    order_reg = taps;
    orders_seen[taps] = 1'b1;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_item(CMD_BITS'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                   INDEX_BITS'($urandom), SAMPLE_BITS'($urandom), COEF_BITS'($urandom),
                   DELAY_BITS'({$urandom, $urandom}));
      1: write_coef(iirtdf2_pkg::CMD_WR_NUM,
                    INDEX_BITS'($urandom_range(MAX_ORDER + 1, 15)), pick_coef());
      2: write_coef(iirtdf2_pkg::CMD_WR_DEN, $urandom_range(0, 1) ? INDEX_BITS'(0) :
                    INDEX_BITS'($urandom_range(MAX_ORDER + 1, 15)), pick_coef());
      3: load_delay(INDEX_BITS'($urandom_range(MAX_ORDER, 15)), pick_state_word());
      default: read_delay(INDEX_BITS'($urandom_range(MAX_ORDER, 15)));
    endcase
  endtask

  // order zero: pure gain, saturation at both rails, rounding of half an lsb
  task automatic test_pure_gain_and_clipping();
    set_order('0);
    write_coef(iirtdf2_pkg::CMD_WR_NUM, 4'd0, 18'h1FFFF);
    filter_sample(16'h7FFF);
    filter_sample(16'h8000);
    write_coef(iirtdf2_pkg::CMD_WR_NUM, 4'd0, 18'h20000);
    filter_sample(16'h8000);
    write_coef(iirtdf2_pkg::CMD_WR_NUM, 4'd0, 18'd8192);
    filter_sample(16'd1);
    filter_sample(16'hFFFF);
    write_coef(iirtdf2_pkg::CMD_WR_NUM, 4'd0, 18'd16384);
    filter_sample(16'h8000);
  endtask

  // writes, loads and reads out of range, denominator entry zero, unused commands
  task automatic test_ignored_items();
    write_coef(iirtdf2_pkg::CMD_WR_DEN, 4'd0, 18'h1FFFF);
    write_coef(iirtdf2_pkg::CMD_WR_NUM, 4'd9, 18'h1FFFF);
    write_coef(iirtdf2_pkg::CMD_WR_DEN, 4'd15, 18'h20000);
    load_delay(4'(MAX_ORDER), 40'h7F_FFFF_FFFF);
    load_delay(4'd15, 40'h80_0000_0000);
    read_delay(4'd15);
    send_item(CMD_SPARE_FIRST, 4'd3, 16'h7FFF, 18'h1FFFF, 40'h7F_FFFF_FFFF);
    send_item(CMD_SPARE_LAST, 4'd15, 16'h8000, 18'h20000, 40'h80_0000_0000);
  endtask

  // delay word saturates at 40 bits; words above the order stay untouched
  task automatic test_delay_saturation();
    set_order(4'd2);
    load_delay(4'd1, 40'h7F_FFFF_FFFF);
    write_coef(iirtdf2_pkg::CMD_WR_NUM, 4'd1, 18'h1FFFF);
    load_delay(4'd5, pick_state_word());
    filter_sample(16'h7FFF);
    read_delay(4'd0);
    read_delay(4'd1);
    read_delay(4'd5);
  endtask

  // receiver holds off for a long stretch while the sender keeps pushing
  task automatic test_input_backpressure();
    int i;
    set_order(4'(MAX_ORDER));
    sender_gaps = 1'b0;
    stall_mode = STALL_NONE;
    hold_request = LONG_HOLD;
    for (i = 0; i < 40; i++) filter_sample(pick_sample());
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_filters();
    int phase;
    int order;
    int n_eff;
    int stream_len;
    int roll;
    int i;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0) order = MAX_ORDER;
      else if (phase == 1) order = 0;
      else if ($urandom_range(0, 7) == 0) order = $urandom_range(MAX_ORDER + 1, 15);
      else order = $urandom_range(0, MAX_ORDER);
      set_order(TAPS_BITS'(order));
      n_eff = (order > MAX_ORDER) ? MAX_ORDER : order;
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      sender_gaps = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        stall_mode = STALL_NONE;
        sender_gaps = 1'b0;
      end
      // well-formed setup: full coefficient set, optional initial state
      for (i = 0; i <= n_eff; i++)
        write_coef(iirtdf2_pkg::CMD_WR_NUM, INDEX_BITS'(i), pick_coef());
      for (i = 1; i <= n_eff; i++)
        write_coef(iirtdf2_pkg::CMD_WR_DEN, INDEX_BITS'(i), pick_coef());
      if ($urandom_range(0, 1) == 0) begin
        for (i = 0; i < MAX_ORDER; i++) load_delay(INDEX_BITS'(i), pick_state_word());
      end
      stream_len = $urandom_range(20, 60);
      for (i = 0; i < stream_len; i++) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) send_noise();
        else if (roll == 1)
          write_coef(iirtdf2_pkg::CMD_WR_NUM, INDEX_BITS'($urandom_range(0, MAX_ORDER)),
                     pick_coef());
        else if (roll == 2)
          write_coef(iirtdf2_pkg::CMD_WR_DEN, INDEX_BITS'($urandom_range(1, MAX_ORDER)),
                     pick_coef());
        else if (roll == 3)
          load_delay(INDEX_BITS'($urandom_range(0, MAX_ORDER - 1)), pick_state_word());
        else if (roll == 4)
          read_delay(INDEX_BITS'($urandom_range(0, MAX_ORDER - 1)));
        else
          filter_sample(pick_sample());
      end
      // final state readback
      for (i = 0; i < MAX_ORDER; i++) read_delay(INDEX_BITS'(i));
      phase++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_pure_gain_and_clipping();
    test_ignored_items();
    test_delay_saturation();
    test_input_backpressure();
    test_random_filters();
    in_valid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d items (%0d filter samples) over %0d distinct filter orders",
             items_sent, samples_sent, $countones(orders_seen));
    $display("checked %0d result items, %0d mismatches", results_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
